// ===== rtl/core/cedh_pkg.sv =====
// ----------------------------------------------------------------------------
// cedh_pkg
// Shared types and constants of the CMY error-diffusion halftoner.
// ----------------------------------------------------------------------------
package cedh_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_LINE_DEF = 4096;
  localparam int ACC_BITS_DEF = 12;

  // Channel count (cyan, magenta, yellow)
  localparam int NUM_CH = 3;

  // Register reset values
  localparam logic [12:0] LINE_WIDTH_RST = 13'd640;
  localparam logic [8:0]  THRESHOLD_RST  = 9'd127;

  // Register select, taken from paddr bit 2
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  // Request types
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  // Input transaction
  typedef struct packed {
    logic       req_type;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] table_index;
    logic [7:0] table_value;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic        cyan_dot;
    logic        magenta_dot;
    logic        yellow_dot;
    logic [11:0] pixel_position;
    logic        line_end;
  } out_item_t;

  // Diffusion stage status seen by the line store
  typedef struct packed {
    logic advance;
    logic last;
    logic first;
  } ls_ctl_t;

endpackage

// ===== rtl/core/cedh_gamma.sv =====
// ----------------------------------------------------------------------------
// cedh_gamma
// Three copies of the 256-entry gamma table, one read port per channel.
// ----------------------------------------------------------------------------
module cedh_gamma (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [7:0]                     wr_addr_i,
  input  logic [7:0]                     wr_data_i,
  input  logic                           rd_en_i,
  input  logic [cedh_pkg::NUM_CH-1:0][7:0] rd_addr_i,
  output logic [cedh_pkg::NUM_CH-1:0][7:0] rd_data_o
);

  // One table copy per channel, all written together
  for (genvar ch = 0; ch < cedh_pkg::NUM_CH; ch++) begin : g_ch
    logic [7:0] lut_q [256];
    logic [7:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_en_i) begin
        lut_q[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= lut_q[rd_addr_i[ch]];
      end
    end

    assign rd_data_o[ch] = rd_q;
  end

endmodule

// ===== rtl/core/cedh_line_store.sv =====
// ----------------------------------------------------------------------------
// cedh_line_store
// Next-row error memory with clearing pass, deferred second write and
// read forwarding.
// ----------------------------------------------------------------------------
module cedh_line_store #(
  parameter int MaxLine = cedh_pkg::MAX_LINE_DEF,
  parameter int AccBits = cedh_pkg::ACC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    rd_en_i,
  input  logic [$clog2(MaxLine)-1:0]              rd_addr_i,
  output logic [cedh_pkg::NUM_CH*AccBits-1:0]     rd_data_o,
  input  cedh_pkg::ls_ctl_t                       ctl_i,
  input  logic [$clog2(MaxLine)-1:0]              col_i,
  input  logic [cedh_pkg::NUM_CH*AccBits-1:0]     left_data_i,
  input  logic [cedh_pkg::NUM_CH*AccBits-1:0]     here_data_i,
  output logic                                    busy_o
);

  localparam int ColW  = $clog2(MaxLine);
  localparam int DataW = cedh_pkg::NUM_CH * AccBits;

  logic [DataW-1:0] err_ram_q [MaxLine];
  logic [DataW-1:0] rd_q;
  logic             fwd_q;
  logic [DataW-1:0] fwd_data_q;
  logic             fwd_d;
  logic [DataW-1:0] fwd_data_d;

  logic             clr_q;
  logic [ColW-1:0]  clr_cnt_q;

  logic             def_v_q;
  logic             def_v_d;
  logic [ColW-1:0]  def_addr_q;
  logic [DataW-1:0] def_data_q;

  logic             wr_left;
  logic             wr_here;
  logic             def_set;
  logic             drain;
  logic [ColW-1:0]  col_left;
  logic             we;
  logic [ColW-1:0]  waddr;
  logic [DataW-1:0] wdata;

  // Decode the writes the diffusion stage commits at this edge
  always_comb begin
    col_left = col_i - ColW'(1);
    wr_left  = ctl_i.advance & ~ctl_i.first;
    wr_here  = ctl_i.advance & ctl_i.first & ctl_i.last;
    def_set  = ctl_i.advance & ctl_i.last & ~ctl_i.first;
    drain    = def_v_q & ~wr_left & ~wr_here & ~clr_q;
  end

  // Arbitrate the single write port
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt_q;
    wdata = '0;
    if (clr_q) begin
      we = 1'b1;
    end else if (wr_left) begin
      we    = 1'b1;
      waddr = col_left;
      wdata = left_data_i;
    end else if (wr_here) begin
      we    = 1'b1;
      waddr = col_i;
      wdata = here_data_i;
    end else if (drain) begin
      we    = 1'b1;
      waddr = def_addr_q;
      wdata = def_data_q;
    end
  end

  // Pick the newest pending value for the address being read
  always_comb begin
    fwd_d      = 1'b0;
    fwd_data_d = def_data_q;
    if (ctl_i.advance && ctl_i.last && rd_addr_i == col_i) begin
      fwd_d      = 1'b1;
      fwd_data_d = here_data_i;
    end else if (wr_left && rd_addr_i == col_left) begin
      fwd_d      = 1'b1;
      fwd_data_d = left_data_i;
    end else if (def_v_q && rd_addr_i == def_addr_q) begin
      fwd_d = 1'b1;
    end
  end

  // Hold a second write of a line end until the port is free
  always_comb begin
    def_v_d = def_v_q;
    if (def_set) begin
      def_v_d = 1'b1;
    end else if (drain) begin
      def_v_d = 1'b0;
    end
  end

  // Memory array
  always_ff @(posedge clk_i) begin
    if (we) begin
      err_ram_q[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_q <= err_ram_q[rd_addr_i];
    end
  end

  // Forward and deferred payload
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= fwd_data_d;
    end
    if (def_set) begin
      def_addr_q <= col_i;
      def_data_q <= here_data_i;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      def_v_q   <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + ColW'(1);
        if (clr_cnt_q == ColW'(MaxLine - 1)) begin
          clr_q <= 1'b0;
        end
      end
      def_v_q <= def_v_d;
      if (rd_en_i) begin
        fwd_q <= fwd_d;
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;
  assign busy_o    = clr_q;

  // A new deferred write never lands on one still waiting
  a_def_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    def_set |-> !def_v_q)
    else $error("deferred line store write overwritten");

  // No read while the clearing pass runs
  a_no_rd_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> !clr_q)
    else $error("line store read during clearing pass");

  // No pixel commits while the clearing pass runs
  a_no_wr_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.advance |-> !clr_q)
    else $error("line store write during clearing pass");

endmodule

// ===== rtl/core/cedh_diffuse.sv =====
// ----------------------------------------------------------------------------
// cedh_diffuse
// Per-pixel threshold and Floyd-Steinberg error split for three channels,
// holding the right carry and the two pending below sums.
// ----------------------------------------------------------------------------
module cedh_diffuse #(
  parameter int AccBits = cedh_pkg::ACC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       advance_i,
  input  logic                                       spread_i,
  input  logic                                       last_i,
  input  logic [8:0]                                 thresh_i,
  input  logic [cedh_pkg::NUM_CH-1:0][7:0]           gamma_i,
  input  logic [cedh_pkg::NUM_CH-1:0][AccBits-1:0]   err_above_i,
  output logic [cedh_pkg::NUM_CH-1:0]                dots_o,
  output logic [cedh_pkg::NUM_CH-1:0][AccBits-1:0]   err_left_o,
  output logic [cedh_pkg::NUM_CH-1:0][AccBits-1:0]   err_here_o
);

  localparam int A = AccBits;
  localparam logic signed [A+1:0] AccMax = (A+2)'((1 << (A - 1)) - 1);
  localparam logic signed [A+1:0] AccMin = (A+2)'(-(1 << (A - 1)));

  logic [cedh_pkg::NUM_CH-1:0][A-1:0] carry_q, carry_d;
  logic [cedh_pkg::NUM_CH-1:0][A-1:0] below0_q, below0_d;
  logic [cedh_pkg::NUM_CH-1:0][A-1:0] below1_q, below1_d;

  // Clamp to the accumulator range
  function automatic logic [A-1:0] sat_acc(input logic signed [A+1:0] x);
    if (x > AccMax) begin
      return AccMax[A-1:0];
    end
    if (x < AccMin) begin
      return AccMin[A-1:0];
    end
    return x[A-1:0];
  endfunction

  // Threshold each channel and split its error
  always_comb begin
    logic [8:0]            inv;
    logic signed [A+1:0]   sum;
    logic [A-1:0]          val;
    logic                  dot;
    logic [A:0]            err;
    logic [A+3:0]          ex;
    logic [A+3:0]          e3;
    logic [A+3:0]          e5;
    logic [A+3:0]          e7;
    logic [A-1:0]          f1;
    logic [A-1:0]          f3;
    logic [A-1:0]          f5;
    logic [A-1:0]          f7;
    logic [A-1:0]          b0n;

    for (int ch = 0; ch < cedh_pkg::NUM_CH; ch++) begin
      inv = 9'd255 - {1'b0, gamma_i[ch]};
      sum = {{(A-7){1'b0}}, inv}
          + {{2{err_above_i[ch][A-1]}}, err_above_i[ch]}
          + {{2{carry_q[ch][A-1]}}, carry_q[ch]};
      val = sat_acc(sum);
      dot = $signed({val[A-1], val}) > $signed({{(A-8){1'b0}}, thresh_i});

      // Remainder after printing, none at the line edges
      if (!spread_i) begin
        err = '0;
      end else if (dot) begin
        err = {val[A-1], val} - (A+1)'(255);
      end else begin
        err = {val[A-1], val};
      end

      // Weights 1, 3, 5, 7 then floor divide by 16
      ex = {{3{err[A]}}, err};
      e3 = ex + (ex << 1);
      e5 = ex + (ex << 2);
      e7 = (ex << 3) - ex;
      f1 = ex[A+3:4];
      f3 = e3[A+3:4];
      f5 = e5[A+3:4];
      f7 = e7[A+3:4];

      b0n = sat_acc({{2{below1_q[ch][A-1]}}, below1_q[ch]} + {{2{f5[A-1]}}, f5});

      dots_o[ch]     = dot;
      err_left_o[ch] = sat_acc({{2{below0_q[ch][A-1]}}, below0_q[ch]}
                             + {{2{f3[A-1]}}, f3});
      err_here_o[ch] = b0n;

      carry_d[ch]  = last_i ? '0 : f7;
      below0_d[ch] = last_i ? '0 : b0n;
      below1_d[ch] = last_i ? '0 : f1;
    end
  end

  // Advance the carries with each finished pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q  <= '0;
      below0_q <= '0;
      below1_q <= '0;
    end else if (advance_i) begin
      carry_q  <= carry_d;
      below0_q <= below0_d;
      below1_q <= below1_d;
    end
  end

endmodule

// ===== rtl/core/cmy_error_diffusion_halftone.sv =====
// ----------------------------------------------------------------------------
// cmy_error_diffusion_halftone
// Flow: a pixel transaction reads the gamma table and line store at its
// accept edge into the diffusion stage, and its dots are registered into the
// output register when the stage advances. Throughput: one transaction per
// cycle while the output is not stalled, set by the error carry loop and the
// single line store write port. Reset: line store clearing of all MAX_LINE
// entries with the input stalled; gamma table undefined until written.
// ----------------------------------------------------------------------------
module cmy_error_diffusion_halftone #(
  parameter int MAX_LINE = cedh_pkg::MAX_LINE_DEF,
  parameter int ACC_BITS = cedh_pkg::ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cedh_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cedh_pkg::out_item_t out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int ColW  = $clog2(MAX_LINE);
  localparam int CmpW  = ($clog2(MAX_LINE + 1) > 13) ? $clog2(MAX_LINE + 1) : 13;
  localparam int DataW = cedh_pkg::NUM_CH * ACC_BITS;

  logic [12:0]         line_width_q;
  logic [8:0]          thresh_q;
  logic                cfg_we;

  logic                accept;
  logic                accept_px;
  logic                accept_tbl;
  logic                advance;
  logic                busy;

  logic [ColW-1:0]     column_q, column_d;
  logic [CmpW-1:0]     width_ext;
  logic [CmpW-1:0]     last_idx;
  logic                last_a;

  logic                s1_valid_q, s1_valid_d;
  logic [ColW-1:0]     s1_col_q;
  logic                s1_last_q;
  logic                s1_spread_q;

  logic                out_valid_q, out_valid_d;
  cedh_pkg::out_item_t out_item_q, out_item_d;

  logic [cedh_pkg::NUM_CH-1:0][7:0]          gamma_addr;
  logic [cedh_pkg::NUM_CH-1:0][7:0]          gamma_data;
  logic [DataW-1:0]                          above_data;
  logic [cedh_pkg::NUM_CH-1:0]               dots;
  logic [cedh_pkg::NUM_CH-1:0][ACC_BITS-1:0] err_left;
  logic [cedh_pkg::NUM_CH-1:0][ACC_BITS-1:0] err_here;
  cedh_pkg::ls_ctl_t                         ls_ctl;

  // Register port
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == cedh_pkg::REG_THRESHOLD) ? 32'(thresh_q)
                                                       : 32'(line_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= cedh_pkg::LINE_WIDTH_RST;
      thresh_q     <= cedh_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      if (paddr[2] == cedh_pkg::REG_LINE_WIDTH) begin
        line_width_q <= pwdata[12:0];
      end else begin
        thresh_q <= pwdata[8:0];
      end
    end
  end

  // Handshake: take a transaction when the diffusion stage is free or moving on and the line store is not clearing
  always_comb begin
    advance    = s1_valid_q & (~out_valid_q | ~out_stall_i);
    in_stall_o = busy | (s1_valid_q & ~advance);
    accept     = in_valid_i & ~in_stall_o;
    accept_px  = accept & (in_item_i.req_type == cedh_pkg::REQ_PIXEL);
    accept_tbl = accept & (in_item_i.req_type == cedh_pkg::REQ_TABLE);
  end

  // Line position of the incoming pixel, width clamped to 1..MAX_LINE
  always_comb begin
    width_ext = CmpW'(line_width_q);
    if (width_ext == '0) begin
      last_idx = '0;
    end else if (width_ext > CmpW'(MAX_LINE)) begin
      last_idx = CmpW'(MAX_LINE - 1);
    end else begin
      last_idx = width_ext - CmpW'(1);
    end
    last_a   = CmpW'(column_q) >= last_idx;
    column_d = last_a ? '0 : column_q + ColW'(1);
  end

  // Diffusion stage occupancy
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_px) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    out_item_d.cyan_dot       = dots[0];
    out_item_d.magenta_dot    = dots[1];
    out_item_d.yellow_dot     = dots[2];
    out_item_d.pixel_position = 12'(s1_col_q);
    out_item_d.line_end       = s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_px) begin
        column_q <= column_d;
      end
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stage and output payload
  always_ff @(posedge clk_i) begin
    if (accept_px) begin
      s1_col_q    <= column_q;
      s1_last_q   <= last_a;
      s1_spread_q <= (column_q != '0) & ~last_a;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Gamma lookup, read with the pixel transaction
  assign gamma_addr[0] = in_item_i.red;
  assign gamma_addr[1] = in_item_i.green;
  assign gamma_addr[2] = in_item_i.blue;

  cedh_gamma u_gamma (
    .clk_i     (clk_i),
    .wr_en_i   (accept_tbl),
    .wr_addr_i (in_item_i.table_index),
    .wr_data_i (in_item_i.table_value),
    .rd_en_i   (accept_px),
    .rd_addr_i (gamma_addr),
    .rd_data_o (gamma_data)
  );

  // Next-row error store
  assign ls_ctl.advance = advance;
  assign ls_ctl.last    = s1_last_q;
  assign ls_ctl.first   = (s1_col_q == '0);

  cedh_line_store #(
    .MaxLine (MAX_LINE),
    .AccBits (ACC_BITS)
  ) u_line_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept_px),
    .rd_addr_i   (column_q),
    .rd_data_o   (above_data),
    .ctl_i       (ls_ctl),
    .col_i       (s1_col_q),
    .left_data_i (err_left),
    .here_data_i (err_here),
    .busy_o      (busy)
  );

  // Threshold and error split
  cedh_diffuse #(
    .AccBits (ACC_BITS)
  ) u_diffuse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .spread_i    (s1_spread_q),
    .last_i      (s1_last_q),
    .thresh_i    (thresh_q),
    .gamma_i     (gamma_data),
    .err_above_i (above_data),
    .dots_o      (dots),
    .err_left_o  (err_left),
    .err_here_o  (err_here)
  );

  // A line end in the stage leaves the column counter at zero
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q |-> column_q == '0)
    else $error("column not wrapped after line end");

  // A blocked output holds the pixel in the diffusion stage
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_col_q))
    else $error("diffusion stage moved while output blocked");

  // A stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

endmodule
